### rtl/sha256_pkg.sv
// shared types, constants and round functions for the sha-256 message hasher
// no dependencies
package sha256_pkg;

    localparam int WORD_W      = 32;
    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 64;

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  valid_bytes;
        logic        last_word;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic        digest_last;
    } out_item_t;

    // word source selected by the controller for the block buffer
    typedef enum logic [2:0] {
        SRC_DATA   = 3'd0,
        SRC_LASTW  = 3'd1,
        SRC_PAD    = 3'd2,
        SRC_ZERO   = 3'd3,
        SRC_LEN_HI = 3'd4,
        SRC_LEN_LO = 3'd5
    } word_src_t;

    // controller to datapath
    typedef struct packed {
        logic      put;          // write a word into the block buffer
        word_src_t src;
        logic      add_len;      // add this item's bit count to the length
        logic      round_start;  // load working vars from hash state
        logic      round_step;   // run one compression round
        logic      fold;         // add working vars into hash state
        logic      restart;      // back to initial values
        logic      emit_shift;   // rotate hash state for output
    } sha_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [3:0] word_pos;
        logic [5:0] round;
    } sha_status_t;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] small_sig0(input logic [31:0] x);
        small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sig1(input logic [31:0] x);
        small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

### rtl/sha256_message_hasher_top.sv
// sha-256 message hasher: one input word per cycle while idle, one item in
// flight; 64-round compression per block at one round per cycle, during which
// no input is taken; a last item costs padding words plus one or two blocks,
// then 8 digest items
// reset: hash state to the initial values, length and counters cleared
module sha256_message_hasher_top (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sha256_pkg::in_item_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sha256_pkg::out_item_t out_data
);

    sha256_pkg::sha_cmd_t    cmd;
    sha256_pkg::sha_status_t status;
    logic [31:0]             dw;
    logic                    last;

    sha256_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_last  (last),
        .cmd       (cmd),
        .status    (status)
    );

    sha256_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_item     (in_data),
        .cmd         (cmd),
        .status      (status),
        .digest_word (dw)
    );

    assign out_data.digest_word = dw;
    assign out_data.digest_last = last;

endmodule

### rtl/sha256_ctrl.sv
// controller state machine for the sha-256 message hasher
// depends on sha256_pkg
module sha256_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  sha256_pkg::in_item_t    in_item,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    out_last,
    output sha256_pkg::sha_cmd_t    cmd,
    input  sha256_pkg::sha_status_t status
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_ROUND = 8'b0000_0010,
        ST_FOLD  = 8'b0000_0100,
        ST_PAD   = 8'b0000_1000,
        ST_FILL  = 8'b0001_0000,
        ST_LENHI = 8'b0010_0000,
        ST_LENLO = 8'b0100_0000,
        ST_EMIT  = 8'b1000_0000
    } state_t;

    state_t     state_reg, state_next;
    state_t     ret_reg, ret_next;         // where to go after a block
    logic [2:0] emit_reg, emit_next;
    logic       full4;

    assign full4 = in_item.valid_bytes[2];   // 4..7 count as four bytes

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        emit_next  = emit_reg;
        cmd        = '0;
        cmd.src    = sha256_pkg::SRC_DATA;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        out_last   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.put     = 1'b1;
                    cmd.add_len = 1'b1;
                    if (!in_item.last_word || full4)
                        cmd.src = sha256_pkg::SRC_DATA;
                    else
                        cmd.src = sha256_pkg::SRC_LASTW;
                    if (in_item.last_word)
                    begin
                        ret_next   = full4 ? ST_PAD : ST_FILL;
                    end
                    else
                        ret_next = ST_IDLE;
                    if (status.word_pos == 4'd15)
                    begin
                        cmd.round_start = 1'b1;
                        state_next      = ST_ROUND;
                    end
                    else if (in_item.last_word)
                        state_next = full4 ? ST_PAD : ST_FILL;
                end
            end
            ST_ROUND:
            begin
                cmd.round_step = 1'b1;
                if (status.round == 6'd63)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                cmd.fold   = 1'b1;
                state_next = ret_reg;
                if (ret_reg == ST_EMIT)
                    emit_next = '0;
            end
            ST_PAD:
            begin
                cmd.put    = 1'b1;
                cmd.src    = sha256_pkg::SRC_PAD;
                ret_next   = ST_FILL;
                state_next = ST_FILL;
                if (status.word_pos == 4'd15)
                begin
                    cmd.round_start = 1'b1;
                    state_next      = ST_ROUND;
                end
            end
            ST_FILL:
            begin
                // zeros until slot 14, wrapping through a block if past it
                if (status.word_pos == 4'd14)
                    state_next = ST_LENHI;
                else
                begin
                    cmd.put  = 1'b1;
                    cmd.src  = sha256_pkg::SRC_ZERO;
                    ret_next = ST_FILL;
                    if (status.word_pos == 4'd15)
                    begin
                        cmd.round_start = 1'b1;
                        state_next      = ST_ROUND;
                    end
                end
            end
            ST_LENHI:
            begin
                cmd.put    = 1'b1;
                cmd.src    = sha256_pkg::SRC_LEN_HI;
                state_next = ST_LENLO;
            end
            ST_LENLO:
            begin
                cmd.put         = 1'b1;
                cmd.src         = sha256_pkg::SRC_LEN_LO;
                cmd.round_start = 1'b1;
                ret_next        = ST_EMIT;
                state_next      = ST_ROUND;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                out_last  = (emit_reg == 3'd7);
                if (out_ready)
                begin
                    cmd.emit_shift = 1'b1;
                    emit_next      = emit_reg + 3'd1;
                    if (emit_reg == 3'd7)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            emit_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            emit_reg  <= emit_next;
        end
    end

endmodule

### rtl/sha256_dp.sv
// datapath: block buffer, message schedule, round logic, hash state, length
// depends on sha256_pkg
module sha256_dp (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sha256_pkg::in_item_t    in_item,
    input  sha256_pkg::sha_cmd_t    cmd,
    output sha256_pkg::sha_status_t status,
    output logic [31:0]             digest_word
);

    logic [31:0] w_reg [16];     // message schedule window, w_reg[0] is current
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];      // a..h
    logic [63:0] len_reg;
    logic [3:0]  pos_reg;
    logic [5:0]  rnd_reg;

    logic [31:0] wr_word, keep, padb, w_new, t1, t2;
    logic [2:0]  nb;
    logic [5:0]  add_bits;

    always_comb
    begin
        nb = (!in_item.last_word || in_item.valid_bytes[2]) ? 3'd4 : in_item.valid_bytes;
        add_bits = {nb, 3'b000};
        case (in_item.valid_bytes[1:0])
            2'd0:    begin keep = 32'h00000000; padb = 32'h80000000; end
            2'd1:    begin keep = 32'hff000000; padb = 32'h00800000; end
            2'd2:    begin keep = 32'hffff0000; padb = 32'h00008000; end
            default: begin keep = 32'hffffff00; padb = 32'h00000080; end
        endcase
        case (cmd.src)
            sha256_pkg::SRC_DATA:   wr_word = in_item.data_word;
            sha256_pkg::SRC_LASTW:  wr_word = (in_item.data_word & keep) | padb;
            sha256_pkg::SRC_PAD:    wr_word = 32'h80000000;
            sha256_pkg::SRC_LEN_HI: wr_word = len_reg[63:32];
            sha256_pkg::SRC_LEN_LO: wr_word = len_reg[31:0];
            default:                wr_word = '0;
        endcase
        w_new = w_reg[0] + sha256_pkg::small_sig0(w_reg[1]) + w_reg[9]
              + sha256_pkg::small_sig1(w_reg[14]);
        t1 = v_reg[7] + sha256_pkg::big_sig1(v_reg[4])
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + sha256_pkg::ROUND_K[rnd_reg] + w_reg[0];
        t2 = sha256_pkg::big_sig0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    end

    assign status.word_pos = pos_reg;
    assign status.round    = rnd_reg;
    assign digest_word     = h_reg[0];

    // block buffer shifts in at the top; after 16 puts w_reg[0] holds word 0
    always_ff @(posedge clk)
    begin
        if (cmd.put)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wr_word;
        end
        else if (cmd.round_step)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha256_pkg::INIT_HASH[i];
                v_reg[i] <= '0;
            end
            len_reg <= '0;
            pos_reg <= '0;
            rnd_reg <= '0;
        end
        else
        begin
            if (cmd.add_len)
                len_reg <= len_reg + {58'd0, add_bits};
            if (cmd.put)
                pos_reg <= pos_reg + 4'd1;
            if (cmd.round_start)
            begin
                for (int i = 0; i < 8; i++)
                    v_reg[i] <= h_reg[i];
            end
            else if (cmd.round_step)
            begin
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
                rnd_reg  <= rnd_reg + 6'd1;
            end
            if (cmd.fold)
            begin
                for (int i = 0; i < 8; i++)
                    h_reg[i] <= h_reg[i] + v_reg[i];
            end
            else if (cmd.restart)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= sha256_pkg::INIT_HASH[i];
                    v_reg[i] <= '0;
                end
                len_reg <= '0;
                pos_reg <= '0;
                rnd_reg <= '0;
            end
            else if (cmd.emit_shift)
            begin
                for (int i = 0; i < 7; i++)
                    h_reg[i] <= h_reg[i+1];
                h_reg[7] <= h_reg[0];
            end
        end
    end

endmodule
